// ===== design/rgbmf_pkg.sv =====
`timescale 1ns / 1ps

package rgbmf_pkg;

   localparam int PIX_W        = 24;
   localparam int CHAN_W       = 8;
   localparam int WIN_SIZE     = 9;
   localparam int WIN_CENTRE   = 4;
   localparam int CFG_WIDTH_W  = 12;
   localparam int CFG_HEIGHT_W = 13;
   localparam int CSR_DATA_W   = 13;

   typedef logic [11:0] row_type;
   localparam row_type ROW_LIMIT = 12'd4095;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic       action;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_word_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       frame_end;
   } rsp_word_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== design/rgbmf_ram.sv =====
`timescale 1ns / 1ps

module rgbmf_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      // hold read data while no read is issued
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/rgbmf_div.sv =====
`timescale 1ns / 1ps

module rgbmf_div #(
   parameter int QW = 23,
   parameter int WW = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [QW-1:0]             dividend,
   input  logic [WW-1:0]             divisor,
   output rgbmf_pkg::div_status_type status,
   output logic [QW-1:0]             quotient,
   output logic [WW-1:0]             remainder
);

   localparam int NW = $clog2(QW + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [NW-1:0] cnt_ff;
   logic [WW-1:0] rem_ff;
   logic [WW-1:0] rem_in;
   logic [QW-1:0] quo_ff;
   logic [QW-1:0] quo_in;
   logic [WW-1:0] den_ff;
   logic [WW:0]   trial;
   logic          fits;

   // one restoring step: bring down the next dividend bit, subtract if it fits
   always_comb begin
      trial  = {rem_ff, quo_ff[QW-1]};
      fits   = trial >= {1'b0, den_ff};
      rem_in = fits ? WW'(trial - {1'b0, den_ff}) : trial[WW-1:0];
      quo_in = {quo_ff[QW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= NW'(QW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - NW'(1);
            if (cnt_ff == NW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule

// ===== design/rgb_median_filter_3x3_unit.sv =====
`timescale 1ns / 1ps
// Throughput: one word per cycle while neither rsp_stall nor a csr update holds
// the input, set by the one read and one write of the line store per word (read
// on accept, write when the word leaves stage 1, forwarded).
// A csr write stalls input while a bit-serial divider re-derives the output row
// and column. Reset clears counters, valid flags and window; line store is not cleared.

module rgb_median_filter_3x3_unit #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rgbmf_pkg::req_word_type             req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rgbmf_pkg::rsp_word_type             rsp_data,
   input  logic                                csr_we,
   input  rgbmf_pkg::csr_index_type            csr_index,
   input  logic [rgbmf_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int QW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int PW  = rgbmf_pkg::PIX_W;
   localparam int CHW = rgbmf_pkg::CHAN_W;
   localparam int NWIN = rgbmf_pkg::WIN_SIZE;
   localparam int CTR = rgbmf_pkg::WIN_CENTRE;

   function automatic logic [CHW-1:0] min2(input logic [CHW-1:0] a, input logic [CHW-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [CHW-1:0] max2(input logic [CHW-1:0] a, input logic [CHW-1:0] b);
      return (a < b) ? b : a;
   endfunction

   function automatic logic [CHW-1:0] med3(input logic [CHW-1:0] a, input logic [CHW-1:0] b,
                                           input logic [CHW-1:0] c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   // configuration
   logic [rgbmf_pkg::CFG_WIDTH_W-1:0]  width_ff;
   logic [rgbmf_pkg::CFG_HEIGHT_W-1:0] height_ff;
   logic [WW-1:0] w_c;
   logic [HW-1:0] h_c;
   logic [AW-1:0] area_ff;
   logic          div_start_ff;

   // stream position
   logic [CW-1:0]          col_ff, col_in, col_eff;
   rgbmf_pkg::row_type     row_ff, row_in;
   logic [QW-1:0]          q_ff, q_in, qr_ff, qr_in;
   logic [CW-1:0]          qc_ff, qc_in;
   logic                   emit0, interior0, last0, wrap0;

   // divider
   rgbmf_pkg::div_status_type div_status;
   logic [QW-1:0]             div_quot;
   logic [WW-1:0]             div_rem;
   logic                      blk_busy;

   // handshake
   logic ready1, ready2, ready3, ready4, ready5;
   logic acc, s1_go;

   // stage 1: line store read data
   logic          s1_valid_ff;
   logic [CW-1:0] s1_col_ff;
   logic [PW-1:0] s1_pix_ff;
   logic          s1_emit_ff, s1_interior_ff, s1_last_ff;
   logic          s1_fwd_hit_ff;
   logic [2*PW-1:0] s1_fwd_data_ff;
   logic [PW-1:0] pix0;
   logic [2*PW-1:0] ram_rdata, rd_word, wr_word;
   logic [PW-1:0] top_px, mid_px;
   logic [PW-1:0] window_ff [NWIN];
   logic [PW-1:0] window_in [NWIN];

   // stage 2: window snapshot
   logic          s2_valid_ff, s2_interior_ff, s2_last_ff;
   logic [PW-1:0] s2_win_ff [NWIN];

   // stage 3: each column sorted, per channel [channel][column]
   logic          s3_valid_ff, s3_interior_ff, s3_last_ff;
   logic [PW-1:0] s3_centre_ff;
   logic [CHW-1:0] s3_lo_ff [3][3];
   logic [CHW-1:0] s3_md_ff [3][3];
   logic [CHW-1:0] s3_hi_ff [3][3];

   // stage 4: three candidates per channel
   logic          s4_valid_ff, s4_interior_ff, s4_last_ff;
   logic [PW-1:0] s4_centre_ff;
   logic [CHW-1:0] s4_lo_ff [3];
   logic [CHW-1:0] s4_md_ff [3];
   logic [CHW-1:0] s4_hi_ff [3];

   // stage 5: result word
   logic                    rsp_valid_ff;
   rgbmf_pkg::rsp_word_type rsp_ff;
   logic [PW-1:0]           res_px;

   always_comb begin
      if (width_ff == '0) begin
         w_c = WW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_c = WW'(MAX_WIDTH);
      end else begin
         w_c = WW'(width_ff);
      end
      if (height_ff == '0) begin
         h_c = HW'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_c = HW'(MAX_HEIGHT);
      end else begin
         h_c = HW'(height_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= rgbmf_pkg::CFG_WIDTH_W'(640);
         height_ff    <= rgbmf_pkg::CFG_HEIGHT_W'(480);
         div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= csr_we;
         if (csr_we) begin
            case (csr_index)
               rgbmf_pkg::CSR_IMAGE_WIDTH: begin
                  width_ff <= csr_wdata[rgbmf_pkg::CFG_WIDTH_W-1:0];
               end
               rgbmf_pkg::CSR_IMAGE_HEIGHT: begin
                  height_ff <= csr_wdata[rgbmf_pkg::CFG_HEIGHT_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      area_ff <= AW'(AW'(w_c) * AW'(h_c));
   end

   // re-derive output row and column from the output count after a csr write
   rgbmf_div #(
      .QW (QW),
      .WW (WW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_ff),
      .dividend  (q_ff),
      .divisor   (w_c),
      .status    (div_status),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   assign blk_busy = div_start_ff || div_status.busy || div_status.done;

   // pipeline advance
   assign ready5    = !rsp_valid_ff || !rsp_stall;
   assign ready4    = !s4_valid_ff || ready5;
   assign ready3    = !s3_valid_ff || ready4;
   assign ready2    = !s2_valid_ff || ready3;
   assign ready1    = !s1_valid_ff || ready2;
   assign req_stall = !ready1 || blk_busy || csr_we;
   assign acc       = req_valid && !req_stall;
   assign s1_go     = s1_valid_ff && ready2;

   // stage 0: position bookkeeping on the accepted word
   always_comb begin
      col_eff   = (32'(col_ff) >= 32'(w_c)) ? '0 : col_ff;
      emit0     = (row_ff >= rgbmf_pkg::row_type'(2)) ||
                  ((row_ff == rgbmf_pkg::row_type'(1)) && (col_eff != '0));
      wrap0     = (32'(col_eff) + 32'd1) >= 32'(w_c);
      interior0 = (w_c >= WW'(3)) && (h_c >= HW'(3)) &&
                  (qr_ff != '0) && ((32'(qr_ff) + 32'd2) <= 32'(h_c)) &&
                  (qc_ff != '0) && ((32'(qc_ff) + 32'd2) <= 32'(w_c));
      last0     = (AW'(q_ff) + AW'(1)) >= area_ff;
      pix0      = req_data.action ? '0
                                  : {req_data.red_in, req_data.green_in, req_data.blue_in};
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      q_in   = q_ff;
      qr_in  = qr_ff;
      qc_in  = qc_ff;
      if (div_status.done) begin
         qr_in = div_quot;
         qc_in = CW'(div_rem);
      end else if (acc) begin
         if (wrap0) begin
            col_in = '0;
            if (row_ff != rgbmf_pkg::ROW_LIMIT) begin
               row_in = row_ff + rgbmf_pkg::row_type'(1);
            end
         end else begin
            col_in = col_eff + CW'(1);
         end
         if (emit0) begin
            if (last0) begin
               // frame done: restart at the top left
               col_in = '0;
               row_in = '0;
               q_in   = '0;
               qr_in  = '0;
               qc_in  = '0;
            end else begin
               q_in = q_ff + QW'(1);
               if ((32'(qc_ff) + 32'd1) >= 32'(w_c)) begin
                  qc_in = '0;
                  qr_in = qr_ff + QW'(1);
               end else begin
                  qc_in = qc_ff + CW'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         q_ff   <= '0;
         qr_ff  <= '0;
         qc_ff  <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         q_ff   <= q_in;
         qr_ff  <= qr_in;
         qc_ff  <= qc_in;
      end
   end

   // line store: per column {line above previous, previous line}
   rgbmf_ram #(
      .WIDTH (2 * PW),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_col_ff),
      .wr_data (wr_word),
      .rd_en   (acc),
      .rd_addr (col_eff),
      .rd_data (ram_rdata)
   );

   // stage 1: take forwarded word when the previous word wrote the same column
   always_comb begin
      rd_word = s1_fwd_hit_ff ? s1_fwd_data_ff : ram_rdata;
      top_px  = rd_word[2*PW-1:PW];
      mid_px  = rd_word[PW-1:0];
      wr_word = {mid_px, s1_pix_ff};
      for (int r = 0; r < 3; r++) begin
         window_in[r*3]     = window_ff[r*3 + 1];
         window_in[r*3 + 1] = window_ff[r*3 + 2];
      end
      window_in[2] = top_px;
      window_in[5] = mid_px;
      window_in[8] = s1_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         for (int i = 0; i < NWIN; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         if (ready1) begin
            s1_valid_ff <= acc;
         end
         if (s1_go) begin
            for (int i = 0; i < NWIN; i++) begin
               window_ff[i] <= window_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_col_ff      <= col_eff;
         s1_pix_ff      <= pix0;
         s1_emit_ff     <= emit0;
         s1_interior_ff <= interior0;
         s1_last_ff     <= last0;
         s1_fwd_hit_ff  <= s1_go && (s1_col_ff == col_eff);
         s1_fwd_data_ff <= wr_word;
      end
   end

   // stage 2: drop words that give no result
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (ready2) begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready2) begin
         s2_interior_ff <= s1_interior_ff;
         s2_last_ff     <= s1_last_ff;
         for (int i = 0; i < NWIN; i++) begin
            s2_win_ff[i] <= window_in[i];
         end
      end
   end

   // stage 3: sort each window column
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (ready3) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready3) begin
         s3_interior_ff <= s2_interior_ff;
         s3_last_ff     <= s2_last_ff;
         s3_centre_ff   <= s2_win_ff[CTR];
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               s3_lo_ff[k][j] <= min2(min2(s2_win_ff[j][k*CHW +: CHW],
                                           s2_win_ff[3 + j][k*CHW +: CHW]),
                                      s2_win_ff[6 + j][k*CHW +: CHW]);
               s3_md_ff[k][j] <= med3(s2_win_ff[j][k*CHW +: CHW],
                                      s2_win_ff[3 + j][k*CHW +: CHW],
                                      s2_win_ff[6 + j][k*CHW +: CHW]);
               s3_hi_ff[k][j] <= max2(max2(s2_win_ff[j][k*CHW +: CHW],
                                           s2_win_ff[3 + j][k*CHW +: CHW]),
                                      s2_win_ff[6 + j][k*CHW +: CHW]);
            end
         end
      end
   end

   // stage 4: max of lows, median of middles, min of highs
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (ready4) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready4) begin
         s4_interior_ff <= s3_interior_ff;
         s4_last_ff     <= s3_last_ff;
         s4_centre_ff   <= s3_centre_ff;
         for (int k = 0; k < 3; k++) begin
            s4_lo_ff[k] <= max2(max2(s3_lo_ff[k][0], s3_lo_ff[k][1]), s3_lo_ff[k][2]);
            s4_md_ff[k] <= med3(s3_md_ff[k][0], s3_md_ff[k][1], s3_md_ff[k][2]);
            s4_hi_ff[k] <= min2(min2(s3_hi_ff[k][0], s3_hi_ff[k][1]), s3_hi_ff[k][2]);
         end
      end
   end

   // stage 5: median of the candidates, or centre pixel on the border
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         res_px[k*CHW +: CHW] = s4_interior_ff ? med3(s4_lo_ff[k], s4_md_ff[k], s4_hi_ff[k])
                                               : s4_centre_ff[k*CHW +: CHW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ready5) begin
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready5) begin
         rsp_ff.red_out   <= res_px[2*CHW +: CHW];
         rsp_ff.green_out <= res_px[CHW +: CHW];
         rsp_ff.blue_out  <= res_px[0 +: CHW];
         rsp_ff.frame_end <= s4_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
